/* rtl/core/phps_pkg.sv */
// Package for the pixel histogram with peak scaling block.
// Holds the sizes, the request function codes and the state encoding.
// No dependencies; every other file depends on it.
package phps_pkg;

	// Histogram geometry and count width.
	localparam int NumBins   = 256;
	localparam int BinW      = $clog2(NumBins);
	localparam int CountW    = 24;
	localparam int SampleW   = 8;
	localparam int FuncW     = 2;

	// Bar scale is a power of two; the quotient needs one bit more than its log.
	localparam int BarScale  = 256;
	localparam int BarBits   = $clog2(BarScale) + 1;
	localparam int StepW     = $clog2(BarBits);

	localparam logic [CountW-1:0] CountLimit = {CountW{1'b1}};

	// Request function codes.
	typedef enum logic [FuncW-1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_ACCUM = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ACC  = 4'b0010,
		ST_LOAD = 4'b0100,
		ST_DIV  = 4'b1000
	} state_t;

endpackage

/* rtl/core/phps_req_if.sv */
// Request channel of the histogram block: function code, sample and bin index.
// Depends on phps_pkg for the field widths.
interface phps_req_if;
	logic                             valid;
	logic                             ready;
	logic [phps_pkg::FuncW-1:0]       func;
	logic [phps_pkg::SampleW-1:0]     sample_value;
	logic [phps_pkg::SampleW-1:0]     bin_index;

	modport source (output valid, func, sample_value, bin_index, input ready);
	modport sink   (input valid, func, sample_value, bin_index, output ready);
endinterface

/* rtl/core/phps_rsp_if.sv */
// Response channel of the histogram block: bin count, bar height and peak.
// Depends on phps_pkg for the field widths.
interface phps_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [phps_pkg::CountW-1:0]        bin_count;
	logic [phps_pkg::BarBits-1:0]       bar_height;
	logic [phps_pkg::CountW-1:0]        peak_count;

	modport source (output valid, bin_count, bar_height, peak_count, input ready);
	modport sink   (input valid, bin_count, bar_height, peak_count, output ready);
endinterface

/* rtl/core/pixel_histogram_with_peak_scale.sv */
// Top level of the pixel histogram with peak scaling block.
// Depends on phps_pkg, phps_req_if and phps_rsp_if.
//
// Usage:
// Requests arrive on req (valid/ready). func selects clear, accumulate or read.
// A clear sets all bins and the peak to zero at once. An accumulate reads
// the bin from the count memory, then increments it (saturating) and writes
// it back while the peak is updated.
// A read produces one transfer on rsp with the bin count, the peak and the
// bar height count*256/peak. The bar height comes from a shared restoring
// compare/subtract unit that resolves one quotient bit per cycle, so the
// result is loaded after the memory read at the transfer edge, the load
// state and nine divide steps.
// req.ready is high only while the sequencer is idle, so a new request is
// taken only once the last is done. The unused code is accepted and ignored.
// The response sits in an output register; the block keeps taking clears
// and accumulates while it waits. If rsp is stalled when the next read
// finishes, the last divide step waits for it.
// Reset clears all bins at once through a per-bin valid bit; a bin that is
// not valid reads as zero, so there is no clearing pass after reset.
module pixel_histogram_with_peak_scale (
	input  logic      clk,
	input  logic      arst_n,
	phps_req_if.sink  req,
	phps_rsp_if.source rsp
);
	import phps_pkg::*;

	state_t              state_q;
	func_t               func_in;
	logic                req_fire;
	logic                out_free;
	logic [BinW-1:0]     rd_addr;
	logic                addr_ok;
	logic [BinW-1:0]     addr_q;
	logic                addr_ok_q;

	logic [CountW-1:0]   mem [NumBins];
	logic [NumBins-1:0]  valid_q;
	logic [CountW-1:0]   rd_data_q;
	logic                rd_valid_q;
	logic [CountW-1:0]   cur_count;
	logic [CountW-1:0]   inc_count;

	logic [CountW-1:0]   peak_q;
	logic [CountW-1:0]   count_q;
	logic [CountW:0]     rem_q;
	logic [BarBits-1:0]  quo_q;
	logic [StepW-1:0]    step_q;

	logic                div_ge;
	logic [CountW:0]     div_diff;
	logic [BarBits-1:0]  quo_next;
	logic                last_step;

	logic                out_valid_q;
	logic [CountW-1:0]   out_count_q;
	logic [BarBits-1:0]  out_bar_q;
	logic [CountW-1:0]   out_peak_q;

	// Request decode and address selection.
	assign func_in  = func_t'(req.func);
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign rd_addr  = (func_in == FUNC_ACCUM) ? req.sample_value[BinW-1:0]
	                                          : req.bin_index[BinW-1:0];
	assign addr_ok  = (func_in == FUNC_ACCUM) ? (32'(req.sample_value) < NumBins)
	                                          : (32'(req.bin_index) < NumBins);

	// Count seen by the sequencer; a bin never written since clear reads zero.
	assign cur_count = rd_valid_q ? rd_data_q : '0;
	assign inc_count = cur_count + CountW'(1);

	// Shared compare/subtract unit: one quotient bit per step.
	assign div_ge    = (rem_q >= {1'b0, peak_q});
	assign div_diff  = div_ge ? (rem_q - {1'b0, peak_q}) : rem_q;
	assign quo_next  = {quo_q[BarBits-2:0], div_ge};
	assign last_step = (step_q == '0);

	// Count memory: written on accumulate, read once per accepted request.
	always_ff @(posedge clk) begin
		if (state_q == ST_ACC && addr_ok_q && cur_count != CountLimit) begin
			mem[addr_q] <= inc_count;
		end
		if (req_fire) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Sequencer, bin valid bits and peak register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			peak_q     <= '0;
			addr_q     <= '0;
			addr_ok_q  <= 1'b0;
			step_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						addr_q     <= rd_addr;
						addr_ok_q  <= addr_ok;
						rd_valid_q <= valid_q[rd_addr];
						unique case (func_in)
							FUNC_CLEAR: begin
								valid_q <= '0;
								peak_q  <= '0;
							end
							FUNC_ACCUM: state_q <= ST_ACC;
							FUNC_READ:  state_q <= ST_LOAD;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ACC: begin
					if (addr_ok_q && cur_count != CountLimit) begin
						valid_q[addr_q] <= 1'b1;
						if (inc_count > peak_q) begin
							peak_q <= inc_count;
						end
					end
					state_q <= ST_IDLE;
				end
				ST_LOAD: begin
					step_q  <= StepW'(BarBits - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!last_step) begin
						step_q <= step_q - StepW'(1);
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Divider datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			count_q <= addr_ok_q ? cur_count : '0;
			rem_q   <= {1'b0, (addr_ok_q ? cur_count : CountW'(0))};
			quo_q   <= '0;
		end else if (state_q == ST_DIV && !last_step) begin
			rem_q <= {div_diff[CountW-1:0], 1'b0};
			quo_q <= quo_next;
		end
	end

	// Output register toward the response channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DIV && last_step && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && last_step && out_free) begin
			out_count_q <= count_q;
			out_peak_q  <= peak_q;
			out_bar_q   <= (peak_q == '0) ? '0 : quo_next;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.bin_count  = out_count_q;
	assign rsp.bar_height = out_bar_q;
	assign rsp.peak_count = out_peak_q;

endmodule

/* rtl/core/phps_checker.sv */
// Port-level checker for the pixel histogram block, bound to the top level.
// Depends on phps_pkg and on the top level's req and rsp ports.
module phps_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic [phps_pkg::FuncW-1:0]    req_func,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [phps_pkg::CountW-1:0]   rsp_bin_count,
	input logic [phps_pkg::BarBits-1:0]  rsp_bar_height,
	input logic [phps_pkg::CountW-1:0]   rsp_peak_count
);
	import phps_pkg::*;

	// A pending response stays valid with its bin count unchanged until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_count))
		else $error("response dropped or changed while stalled");

	// A read keeps the request side busy through the load state and the first divide step.
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_func == FUNC_READ |=> !req_ready ##1 !req_ready)
		else $error("request accepted during a read");

	// An accumulate keeps the request side busy for its write-back.
	a_accum_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_func == FUNC_ACCUM |=> !req_ready)
		else $error("request accepted during accumulate write-back");

	// A bin never exceeds the peak, so the bar never exceeds the scale.
	a_scale: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_bin_count <= rsp_peak_count
		&& 32'(rsp_bar_height) <= BarScale)
		else $error("bin count above peak or bar above scale");

endmodule

bind pixel_histogram_with_peak_scale phps_checker u_phps_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_func       (req.func),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_bin_count  (rsp.bin_count),
	.rsp_bar_height (rsp.bar_height),
	.rsp_peak_count (rsp.peak_count)
);
